// ----- rtl/core/dpv_pkg.sv -----
// dpv_pkg: payload structs, field widths and codes for the depth pixel to voxel block
// no dependencies; imported by every module of the block
`default_nettype none

package dpv_pkg;

  localparam int ROW_W   = 9;
  localparam int COL_W   = 10;
  localparam int DEPTH_W = 16;
  localparam int TRIG_W  = 16;
  localparam int SPAN_W  = 24;
  localparam int VOX_W   = 5;
  localparam int STAT_W  = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_TILT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_TILT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPAN_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPAN_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPAN_Z = 3'd7;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_HIT     = 2'd2;

  // back-projection arithmetic: image half sizes stay at or below 2048
  localparam int DIFF_W   = 13;  // signed pixel offset from image centre
  localparam int PROD_W   = 30;  // signed depth * offset
  localparam int MAG_W    = 27;  // |depth * offset| < 2^27
  localparam int K_W      = 28;  // signed back-projected coordinate, mm
  localparam int DIV_W    = 13;  // focal length in pixels
  localparam int RECIP_SH = 27;
  localparam int RECIP_W  = 28;

  typedef struct packed {
    logic [ROW_W-1:0]   pix_row;
    logic [COL_W-1:0]   pix_col;
    logic [DEPTH_W-1:0] depth_mm;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VOX_W-1:0]  vox_x;
    logic [VOX_W-1:0]  vox_y;
    logic [VOX_W-1:0]  vox_z;
    logic [VOX_W-1:0]  grid_row;
  } out_item_t;

  // data that rides alongside the constant divider
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               in_range;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/depth_pixel_to_voxel_top.sv -----
// depth_pixel_to_voxel_top: projects depth pixels through a tilted pinhole camera into voxels
// depends on dpv_pkg and dpv_kdiv
`default_nettype none

// Depth pixel to voxel projection. Each input transaction carries one depth
// pixel (row, column, depth in mm) and produces exactly one result transaction:
// status "depth out of range" when the depth is not strictly between min_depth
// and max_depth, "outside grid" when any voxel index falls off the grid, or
// "voxel hit" with the voxel indices and the flipped height row for the grid
// write. Index fields of non-hit results are zero. The datapath is an eight
// stage pipeline (offset products, a three stage divide by the focal length,
// tilt products, tilt sums, span products, grid check and result register);
// it takes one transaction per clock while results are taken at the output.
// Every stage has its own valid bit and only holds when the stage after
// it is full and held, so empty slots close up behind a stalled result
// register and input is still taken. Configuration registers are written
// through the cfg port at any edge with cfg_we high and must only change
// while no transaction is in flight.
module depth_pixel_to_voxel_top #(
  parameter int IMG_ROWS        = 480,
  parameter int IMG_COLS        = 640,
  parameter int GRID_X          = 32,
  parameter int GRID_Y          = 32,
  parameter int GRID_Z          = 32,
  parameter int FOCAL_LENGTH_PX = 525
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire dpv_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output dpv_pkg::out_item_t                 out_data,
  input  wire                                cfg_we,
  input  wire [dpv_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire [dpv_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import dpv_pkg::*;

  localparam int CR = IMG_ROWS / 2;
  localparam int CC = IMG_COLS / 2;

  // arithmetic widths after the divider
  localparam int DT_W  = DEPTH_W + 1 + TRIG_W;  // depth * trig
  localparam int KT_W  = K_W + TRIG_W;          // coordinate * trig
  localparam int SUM_W = KT_W + 1;
  localparam int W_W   = SUM_W - 15;            // world z, mm
  localparam int WY_W  = W_W + 1;               // world height incl. camera height
  localparam int SP_W  = SPAN_W + 1;            // span as signed operand
  localparam int PX_W  = K_W + SP_W;
  localparam int VXS_W = PX_W + 1;
  localparam int VX_W  = VXS_W - 16;
  localparam int PY_W  = WY_W + SP_W;
  localparam int PZ_W  = W_W + SP_W;
  localparam int VY_W  = PY_W - 16;
  localparam int VZ_W  = PZ_W - 16;

  // ---------------------------------------------------------------- config
  logic [DEPTH_W-1:0]       min_depth_r, max_depth_r;
  logic signed [TRIG_W-1:0] cos_tilt_r, sin_tilt_r, cam_height_r;
  logic [SPAN_W-1:0]        inv_span_x_r, inv_span_y_r, inv_span_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r  <= 16'd200;
      max_depth_r  <= 16'd3000;
      cos_tilt_r   <= 16'sd32767;
      sin_tilt_r   <= '0;
      cam_height_r <= '0;
      inv_span_x_r <= 24'd2097;
      inv_span_y_r <= 24'd2097;
      inv_span_z_r <= 24'd2097;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_DEPTH:  min_depth_r  <= cfg_wdata[DEPTH_W-1:0];
        REG_MAX_DEPTH:  max_depth_r  <= cfg_wdata[DEPTH_W-1:0];
        REG_COS_TILT:   cos_tilt_r   <= $signed(cfg_wdata[TRIG_W-1:0]);
        REG_SIN_TILT:   sin_tilt_r   <= $signed(cfg_wdata[TRIG_W-1:0]);
        REG_CAM_HEIGHT: cam_height_r <= $signed(cfg_wdata[TRIG_W-1:0]);
        REG_INV_SPAN_X: inv_span_x_r <= cfg_wdata[SPAN_W-1:0];
        REG_INV_SPAN_Y: inv_span_y_r <= cfg_wdata[SPAN_W-1:0];
        REG_INV_SPAN_Z: inv_span_z_r <= cfg_wdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake chain
  logic en1, en5, en6, en7, en8;
  logic kd_in_ready, kd_out_valid;
  logic v1_r, v5_r, v6_r, v7_r, out_valid_r;

  assign en8      = !out_valid_r || out_ready;
  assign en7      = !v7_r || en8;
  assign en6      = !v6_r || en7;
  assign en5      = !v5_r || en6;
  assign en1      = !v1_r || kd_in_ready;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r        <= in_valid;
      if (en5) v5_r        <= kd_out_valid;
      if (en6) v6_r        <= v5_r;
      if (en7) v7_r        <= v6_r;
      if (en8) out_valid_r <= v7_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // range test and depth * offset from the principal point
  logic signed [DIFF_W-1:0] dif_y_c, dif_x_c;
  logic signed [PROD_W-1:0] py_c, px_c;
  logic signed [PROD_W-1:0] py1_r, px1_r;
  side_t                    side_c, side1_r;

  always_comb begin
    dif_y_c = $signed(DIFF_W'(CR)) - $signed(DIFF_W'(in_data.pix_row));
    dif_x_c = $signed(DIFF_W'(in_data.pix_col)) - $signed(DIFF_W'(CC));
    py_c    = $signed({1'b0, in_data.depth_mm}) * dif_y_c;
    px_c    = $signed({1'b0, in_data.depth_mm}) * dif_x_c;
    side_c.depth    = in_data.depth_mm;
    side_c.in_range = (min_depth_r < in_data.depth_mm) && (in_data.depth_mm < max_depth_r);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      py1_r   <= py_c;
      px1_r   <= px_c;
      side1_r <= side_c;
    end
  end

  // ---------------------------------------------------------------- stages 2 to 4
  // truncating divide by the focal length
  logic signed [K_W-1:0] ky_k, kx_k;
  side_t                 side_k;

  dpv_kdiv #(
    .DIVISOR (FOCAL_LENGTH_PX)
  ) u_kdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_ready  (kd_in_ready),
    .in_py     (py1_r),
    .in_px     (px1_r),
    .in_side   (side1_r),
    .out_valid (kd_out_valid),
    .out_ready (en5),
    .out_ky    (ky_k),
    .out_kx    (kx_k),
    .out_side  (side_k)
  );

  // ---------------------------------------------------------------- stage 5
  // tilt rotation products and lateral span product
  logic signed [DT_W-1:0] dc5_r, ds5_r;
  logic signed [KT_W-1:0] ks5_r, kc5_r;
  logic signed [PX_W-1:0] pvx5_r;
  logic                   rng5_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      dc5_r  <= $signed({1'b0, side_k.depth}) * cos_tilt_r;
      ds5_r  <= $signed({1'b0, side_k.depth}) * sin_tilt_r;
      ks5_r  <= ky_k * sin_tilt_r;
      kc5_r  <= ky_k * cos_tilt_r;
      pvx5_r <= kx_k * $signed({1'b0, inv_span_x_r});
      rng5_r <= side_k.in_range;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // world coordinates, Q1.15 scaling truncated toward zero
  logic signed [SUM_W-1:0] sz_c, sy_c, sz_b_c, sy_b_c;
  logic signed [VXS_W-1:0] sx_c, sx_b_c;
  logic signed [W_W-1:0]   wz_c;
  logic signed [WY_W-1:0]  wy_c;
  logic signed [W_W-1:0]   wz6_r;
  logic signed [WY_W-1:0]  wy6_r;
  logic signed [VX_W-1:0]  vx6_r;
  logic                    rng6_r;

  always_comb begin
    sz_c   = SUM_W'(dc5_r) + SUM_W'(ks5_r);
    sy_c   = SUM_W'(kc5_r) - SUM_W'(ds5_r);
    sz_b_c = sz_c + (sz_c[SUM_W-1] ? SUM_W'(32767) : SUM_W'(0));
    sy_b_c = sy_c + (sy_c[SUM_W-1] ? SUM_W'(32767) : SUM_W'(0));
    wz_c   = sz_b_c[SUM_W-1:15];
    wy_c   = WY_W'($signed(sy_b_c[SUM_W-1:15])) + WY_W'(cam_height_r);
    // lateral axis shifted by half the grid before truncation
    sx_c   = VXS_W'(pvx5_r) + (VXS_W'(GRID_X / 2) <<< 16);
    sx_b_c = sx_c + (sx_c[VXS_W-1] ? VXS_W'(65535) : VXS_W'(0));
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      wz6_r  <= wz_c;
      wy6_r  <= wy_c;
      vx6_r  <= sx_b_c[VXS_W-1:16];
      rng6_r <= rng5_r;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // height and forward span products
  logic signed [PY_W-1:0] py7_r;
  logic signed [PZ_W-1:0] pz7_r;
  logic signed [VX_W-1:0] vx7_r;
  logic                   rng7_r;

  always_ff @(posedge clk) begin
    if (en7) begin
      py7_r  <= wy6_r * $signed({1'b0, inv_span_y_r});
      pz7_r  <= wz6_r * $signed({1'b0, inv_span_z_r});
      vx7_r  <= vx6_r;
      rng7_r <= rng6_r;
    end
  end

  // ---------------------------------------------------------------- stage 8
  // truncation, grid check and result register
  logic signed [PY_W-1:0] py_b_c;
  logic signed [PZ_W-1:0] pz_b_c;
  logic signed [VY_W-1:0] vy_c;
  logic signed [VZ_W-1:0] vz_c;
  logic                   in_x_c, in_y_c, in_z_c;
  out_item_t              res_c, out_data_r;

  always_comb begin
    py_b_c = py7_r + (py7_r[PY_W-1] ? PY_W'(65535) : PY_W'(0));
    pz_b_c = pz7_r + (pz7_r[PZ_W-1] ? PZ_W'(65535) : PZ_W'(0));
    vy_c   = py_b_c[PY_W-1:16];
    vz_c   = pz_b_c[PZ_W-1:16];
    in_x_c = !vx7_r[VX_W-1] && (vx7_r < $signed(VX_W'(GRID_X)));
    in_y_c = !vy_c[VY_W-1]  && (vy_c  < $signed(VY_W'(GRID_Y)));
    in_z_c = !vz_c[VZ_W-1]  && (vz_c  < $signed(VZ_W'(GRID_Z)));
    res_c  = '0;
    if (!rng7_r) begin
      res_c.status = STATUS_RANGE;
    end else if (!(in_x_c && in_y_c && in_z_c)) begin
      res_c.status = STATUS_OUTSIDE;
    end else begin
      res_c.status   = STATUS_HIT;
      res_c.vox_x    = vx7_r[VOX_W-1:0];
      res_c.vox_y    = vy_c[VOX_W-1:0];
      res_c.vox_z    = vz_c[VOX_W-1:0];
      res_c.grid_row = VOX_W'(GRID_Y - 1) - vy_c[VOX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en8) begin
      out_data_r <= res_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/dpv_kdiv.sv -----
// dpv_kdiv: three stage signed division of two lanes by the constant focal length
// depends on dpv_pkg; reciprocal multiply, back-multiply, one-step correction
`default_nettype none

module dpv_kdiv #(
  parameter int DIVISOR = 525
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire logic signed [dpv_pkg::PROD_W-1:0] in_py,
  input  wire logic signed [dpv_pkg::PROD_W-1:0] in_px,
  input  wire dpv_pkg::side_t                   in_side,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [dpv_pkg::K_W-1:0]        out_ky,
  output logic signed [dpv_pkg::K_W-1:0]        out_kx,
  output dpv_pkg::side_t                        out_side
);
  import dpv_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / DIVISOR);
  localparam logic [DIV_W-1:0]   DIV_C = DIV_W'(DIVISOR);
  localparam int QF_W = MAG_W + RECIP_W;
  localparam int BF_W = MAG_W + DIV_W;

  // stage 2: magnitude and reciprocal estimate
  logic               v2_r, neg_y2_r, neg_x2_r;
  logic [MAG_W-1:0]   mag_y2_r, mag_x2_r, q_y2_r, q_x2_r;
  side_t              side2_r;
  // stage 3: back-multiply
  logic               v3_r, neg_y3_r, neg_x3_r;
  logic [MAG_W-1:0]   mag_y3_r, mag_x3_r, q_y3_r, q_x3_r;
  logic [MAG_W:0]     bp_y3_r, bp_x3_r;
  side_t              side3_r;
  // stage 4: corrected quotient
  logic               v4_r;
  logic signed [K_W-1:0] ky4_r, kx4_r;
  side_t              side4_r;

  logic             en2, en3, en4;
  logic [MAG_W-1:0] mag_y_c, mag_x_c;
  logic [QF_W-1:0]  qf_y_c, qf_x_c;
  logic [BF_W-1:0]  bf_y_c, bf_x_c;
  logic [MAG_W:0]   rem_y_c, rem_x_c;
  logic [K_W-1:0]   qc_y_c, qc_x_c;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign in_ready = en2;

  always_comb begin
    mag_y_c = MAG_W'(in_py[PROD_W-1] ? -in_py : in_py);
    mag_x_c = MAG_W'(in_px[PROD_W-1] ? -in_px : in_px);
    qf_y_c  = QF_W'(mag_y_c) * QF_W'(RECIP);
    qf_x_c  = QF_W'(mag_x_c) * QF_W'(RECIP);
    bf_y_c  = BF_W'(q_y2_r) * BF_W'(DIV_C);
    bf_x_c  = BF_W'(q_x2_r) * BF_W'(DIV_C);
    // estimate is low by at most one
    rem_y_c = {1'b0, mag_y3_r} - bp_y3_r;
    rem_x_c = {1'b0, mag_x3_r} - bp_x3_r;
    qc_y_c  = {1'b0, q_y3_r} + K_W'(rem_y_c >= (MAG_W+1)'(DIV_C));
    qc_x_c  = {1'b0, q_x3_r} + K_W'(rem_x_c >= (MAG_W+1)'(DIV_C));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en2) v2_r <= in_valid;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      neg_y2_r <= in_py[PROD_W-1];
      neg_x2_r <= in_px[PROD_W-1];
      mag_y2_r <= mag_y_c;
      mag_x2_r <= mag_x_c;
      q_y2_r   <= qf_y_c[RECIP_SH +: MAG_W];
      q_x2_r   <= qf_x_c[RECIP_SH +: MAG_W];
      side2_r  <= in_side;
    end
    if (en3) begin
      neg_y3_r <= neg_y2_r;
      neg_x3_r <= neg_x2_r;
      mag_y3_r <= mag_y2_r;
      mag_x3_r <= mag_x2_r;
      q_y3_r   <= q_y2_r;
      q_x3_r   <= q_x2_r;
      bp_y3_r  <= bf_y_c[MAG_W:0];
      bp_x3_r  <= bf_x_c[MAG_W:0];
      side3_r  <= side2_r;
    end
    if (en4) begin
      ky4_r   <= neg_y3_r ? -$signed(qc_y_c) : $signed(qc_y_c);
      kx4_r   <= neg_x3_r ? -$signed(qc_x_c) : $signed(qc_x_c);
      side4_r <= side3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_ky    = ky4_r;
  assign out_kx    = kx4_r;
  assign out_side  = side4_r;

endmodule

`default_nettype wire

// ----- rtl/core/dpv_checker.sv -----
// dpv_checker: port-level assertions for the depth pixel to voxel block
// depends on dpv_pkg; bound to depth_pixel_to_voxel_top at the end of this file
`default_nettype none

module dpv_checker #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32
) (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire dpv_pkg::out_item_t out_data
);
  import dpv_pkg::*;

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result straight after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // misses carry zero indices
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_HIT |->
      out_data.vox_x == '0 && out_data.vox_y == '0 &&
      out_data.vox_z == '0 && out_data.grid_row == '0)
    else $error("non-hit result with nonzero indices");

  // flipped row matches the height index, lateral index on the grid
  a_hit_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_HIT |->
      out_data.grid_row == VOX_W'(GRID_Y - 1) - out_data.vox_y &&
      (GRID_X > 32 || int'(out_data.vox_x) < GRID_X))
    else $error("hit result with inconsistent indices");

endmodule

bind depth_pixel_to_voxel_top dpv_checker #(
  .GRID_X (GRID_X),
  .GRID_Y (GRID_Y)
) u_dpv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
